// ===== hw/rtl/htd_pkg.sv =====
// ============================================================================
// htd_pkg
// Shared types, codes and helpers of the Huffman tree decoder core.
// ============================================================================
package htd_pkg;

   // Default size of the node memory and longest accepted code
   localparam int NODE_DEPTH_DEF  = 512;
   localparam int MAX_CODE_LENGTH = 32;

   // Stream widths
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 16;

   // Request kinds carried on req_tuser
   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_LOAD   = 2'd1;
   localparam logic [1:0] REQ_DECODE = 2'd2;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_LD_START,
      ST_LD_WALK,
      ST_LD_ALLOC,
      ST_DC_START,
      ST_DC_STEP,
      ST_DC_LAND,
      ST_EMIT
   } state_type;

   // One result item handed to the output stage
   typedef struct packed {
      logic [7:0] symbol;
      logic       valid;
      logic       last;
      logic       halted;
      logic       overflow;
   } rsp_item_type;

   // Pick one code bit; positions past the code word read as zero
   function automatic logic code_bit(input logic [31:0] bits, input logic [5:0] pos);
      logic r;
      r = 1'b0;
      if (pos < 6'd32) begin
         r = bits[pos[4:0]];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/huffman_tree_decoder_core.sv =====
// Requests: a clear empties the root entry; a load makes one node read per code bit
//   on the existing path and one write per new node; a decode gives a result per symbol.
// Throughput: one request at a time; each decoded bit takes a step and a land state
//   for the single read port of the node memory (read a node, then test the child).
// Reset: the init state empties the root entry; the fill count hides all other entries.
// ============================================================================
// huffman_tree_decoder_core
// Huffman decoder on a binary code tree held in a node memory.
// ============================================================================
module huffman_tree_decoder_core
   import htd_pkg::*;
#(
   parameter int NODE_DEPTH = NODE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [7:0] symbol, [13:8] code_length, [45:14] code_bits, [53:46] data_byte
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [1:0] req_type
   input  logic [1:0]             req_tuser,
   // result stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [7:0] out_symbol, [8] halted, [9] table_overflow
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // [0] symbol_valid
   output logic                   rsp_tuser,
   output logic                   rsp_tlast
);

   localparam int LW = $clog2(NODE_DEPTH);
   localparam int EW = 2 * LW + 8;

   logic          mem_rd_en, mem_wr_en;
   logic [LW-1:0] mem_rd_addr, mem_wr_addr;
   logic [EW-1:0] mem_rd_data, mem_wr_data;
   logic          item_valid, item_ready;
   rsp_item_type  item;

   htd_node_mem #(
      .DEPTH (NODE_DEPTH),
      .WIDTH (EW)
   ) u_node_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   htd_seq #(
      .NODE_DEPTH (NODE_DEPTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_kind    (req_tuser),
      .symbol      (req_tdata[7:0]),
      .code_length (req_tdata[13:8]),
      .code_bits   (req_tdata[45:14]),
      .data_byte   (req_tdata[53:46]),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .item_valid  (item_valid),
      .item_ready  (item_ready),
      .item        (item)
   );

   htd_rsp_stage u_rsp_stage (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== hw/rtl/htd_node_mem.sv =====
// ============================================================================
// htd_node_mem
// Single-port-write, single-port-read node memory with registered read data.
// Read data holds its value until the next read is issued.
// ============================================================================
module htd_node_mem #(
   parameter int DEPTH = 512,
   parameter int WIDTH = 26
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/htd_seq.sv =====
// ============================================================================
// htd_seq
// Request sequencer: clears the tree, walks and extends it for code loads,
// and steps through it bit by bit for decodes, one node read at a time.
// ============================================================================
module htd_seq
   import htd_pkg::*;
#(
   parameter int NODE_DEPTH = NODE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request item
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_kind,
   input  logic [7:0]                          symbol,
   input  logic [5:0]                          code_length,
   input  logic [31:0]                         code_bits,
   input  logic [7:0]                          data_byte,
   // node memory
   output logic                                mem_rd_en,
   output logic [$clog2(NODE_DEPTH)-1:0]       mem_rd_addr,
   input  logic [2*$clog2(NODE_DEPTH)+7:0]     mem_rd_data,
   output logic                                mem_wr_en,
   output logic [$clog2(NODE_DEPTH)-1:0]       mem_wr_addr,
   output logic [2*$clog2(NODE_DEPTH)+7:0]     mem_wr_data,
   // result item
   output logic                                item_valid,
   input  logic                                item_ready,
   output rsp_item_type                        item
);

   localparam int LW   = $clog2(NODE_DEPTH);
   localparam int EW   = 2 * LW + 8;
   localparam int NUW  = $clog2(NODE_DEPTH + 1);
   localparam int SW   = NUW + 7;
   localparam int L_LO = 8;
   localparam int R_LO = 8 + LW;

   state_type        state_ff, state_in;
   logic [7:0]       sym_ff, sym_in;
   logic [5:0]       len_ff, len_in;
   logic [31:0]      bits_ff, bits_in;
   logic [7:0]       byte_ff, byte_in;
   logic [5:0]       pos_ff, pos_in;
   logic [5:0]       rem_ff, rem_in;
   logic [3:0]       bits_left_ff, bits_left_in;
   logic [LW-1:0]    node_ff, node_in;
   logic [EW-1:0]    par_ff, par_in;
   logic [NUW-1:0]   nodes_used_ff, nodes_used_in;
   logic [LW-1:0]    cur_ff, cur_in;
   logic             halted_ff, halted_in;
   logic             ovf_ff, ovf_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic [2:0]       idx_ff, idx_in;
   logic [7:0]       sym_buf_ff [8];
   logic [7:0]       sym_buf_in [8];

   logic [LW-1:0]    rd_left, rd_right, rd_child, new_node;
   logic [7:0]       rd_sym;
   logic             ld_bit, child_sel, rd_is_leaf;
   logic [SW-1:0]    need_sum;
   logic             overflow_hit, code_bad, item_last;

   // Field views of the node just read
   assign rd_sym     = mem_rd_data[7:0];
   assign rd_left    = mem_rd_data[L_LO +: LW];
   assign rd_right   = mem_rd_data[R_LO +: LW];
   assign rd_is_leaf = (rd_left == '0) && (rd_right == '0);
   assign ld_bit     = code_bit(bits_ff, pos_ff);
   assign child_sel  = (state_ff == ST_LD_WALK) ? ld_bit : byte_ff[7];
   assign rd_child   = child_sel ? rd_right : rd_left;
   assign new_node   = nodes_used_ff[LW-1:0];

   // Room check for the nodes still missing on the load path
   assign need_sum     = SW'(nodes_used_ff) + SW'(rem_ff);
   assign overflow_hit = need_sum > SW'(NODE_DEPTH);
   assign code_bad     = (len_ff == 6'd0) || (int'(len_ff) > MAX_CODE_LENGTH);

   assign item_last = (cnt_ff == 4'd0) || ({1'b0, idx_ff} == (cnt_ff - 4'd1));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (req_kind)
                  REQ_CLEAR:  state_in = ST_CLEAR;
                  REQ_LOAD:   state_in = ST_LD_START;
                  REQ_DECODE: state_in = ST_DC_START;
                  default:    state_in = ST_EMIT;
               endcase
            end
         end
         ST_CLEAR: begin
            state_in = ST_EMIT;
         end
         ST_LD_START: begin
            state_in = code_bad ? ST_EMIT : ST_LD_WALK;
         end
         ST_LD_WALK: begin
            if (rem_ff == 6'd0) begin
               state_in = ST_LD_ALLOC;
            end else if (rd_child != '0) begin
               state_in = ST_LD_WALK;
            end else if (overflow_hit) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_LD_ALLOC;
            end
         end
         ST_LD_ALLOC: begin
            state_in = (rem_ff == 6'd0) ? ST_EMIT : ST_LD_ALLOC;
         end
         ST_DC_START: begin
            state_in = halted_ff ? ST_EMIT : ST_DC_STEP;
         end
         ST_DC_STEP: begin
            if ((bits_left_ff == 4'd0) || (rd_child == '0)) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_DC_LAND;
            end
         end
         ST_DC_LAND: begin
            state_in = ST_DC_STEP;
         end
         ST_EMIT: begin
            if (item_ready && item_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // Datapath and memory controls
   always_comb begin
      sym_in        = sym_ff;
      len_in        = len_ff;
      bits_in       = bits_ff;
      byte_in       = byte_ff;
      pos_in        = pos_ff;
      rem_in        = rem_ff;
      bits_left_in  = bits_left_ff;
      node_in       = node_ff;
      par_in        = par_ff;
      nodes_used_in = nodes_used_ff;
      cur_in        = cur_ff;
      halted_in     = halted_ff;
      ovf_in        = ovf_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      sym_buf_in    = sym_buf_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = '0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = node_ff;
      mem_wr_data   = par_ff;
      req_ready     = 1'b0;
      item_valid    = 1'b0;
      item          = '0;

      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            // empty the root; nodes above the fill count are never read
            mem_wr_en     = 1'b1;
            mem_wr_addr   = '0;
            mem_wr_data   = '0;
            nodes_used_in = NUW'(1);
            cur_in        = '0;
            halted_in     = 1'b0;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               sym_in  = symbol;
               len_in  = code_length;
               bits_in = code_bits;
               byte_in = data_byte;
               ovf_in  = 1'b0;
               cnt_in  = 4'd0;
               idx_in  = 3'd0;
            end
         end
         ST_LD_START: begin
            pos_in      = len_ff - 6'd1;
            rem_in      = len_ff;
            node_in     = '0;
            mem_rd_en   = ~code_bad;
            mem_rd_addr = '0;
         end
         ST_LD_WALK: begin
            // follow existing links; stop at the first missing one
            if (rem_ff == 6'd0) begin
               par_in = mem_rd_data;
            end else if (rd_child != '0) begin
               node_in     = rd_child;
               mem_rd_en   = 1'b1;
               mem_rd_addr = rd_child;
               rem_in      = rem_ff - 6'd1;
               pos_in      = pos_ff - 6'd1;
            end else if (overflow_hit) begin
               ovf_in = 1'b1;
            end else begin
               par_in = mem_rd_data;
            end
         end
         ST_LD_ALLOC: begin
            // link one fresh node per cycle, then place the symbol
            mem_wr_en   = 1'b1;
            mem_wr_addr = node_ff;
            if (rem_ff == 6'd0) begin
               mem_wr_data[7:0] = sym_ff;
            end else begin
               if (ld_bit) begin
                  mem_wr_data[R_LO +: LW] = new_node;
               end else begin
                  mem_wr_data[L_LO +: LW] = new_node;
               end
               nodes_used_in = nodes_used_ff + NUW'(1);
               node_in       = new_node;
               par_in        = '0;
               rem_in        = rem_ff - 6'd1;
               pos_in        = pos_ff - 6'd1;
            end
         end
         ST_DC_START: begin
            if (!halted_ff) begin
               mem_rd_en    = 1'b1;
               mem_rd_addr  = cur_ff;
               bits_left_in = 4'd8;
            end
         end
         ST_DC_STEP: begin
            // take one bit from the current node; a missing branch halts
            if (bits_left_ff != 4'd0) begin
               if (rd_child == '0) begin
                  halted_in = 1'b1;
               end else begin
                  cur_in       = rd_child;
                  mem_rd_en    = 1'b1;
                  mem_rd_addr  = rd_child;
                  byte_in      = {byte_ff[6:0], 1'b0};
                  bits_left_in = bits_left_ff - 4'd1;
               end
            end
         end
         ST_DC_LAND: begin
            // on a leaf: record the symbol and restart from the root
            if (rd_is_leaf) begin
               sym_buf_in[cnt_ff[2:0]] = rd_sym;
               cnt_in                  = cnt_ff + 4'd1;
               cur_in                  = '0;
               mem_rd_en               = 1'b1;
               mem_rd_addr             = '0;
            end
         end
         ST_EMIT: begin
            item_valid    = 1'b1;
            item.symbol   = (cnt_ff == 4'd0) ? 8'd0 : sym_buf_ff[idx_ff];
            item.valid    = (cnt_ff != 4'd0);
            item.last     = item_last;
            item.halted   = halted_ff;
            item.overflow = ovf_ff;
            if (item_ready) begin
               idx_in = idx_ff + 3'd1;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         nodes_used_ff <= NUW'(1);
         cur_ff        <= '0;
         halted_ff     <= 1'b0;
         ovf_ff        <= 1'b0;
         cnt_ff        <= 4'd0;
         idx_ff        <= 3'd0;
         rem_ff        <= 6'd0;
         bits_left_ff  <= 4'd0;
      end else begin
         state_ff      <= state_in;
         nodes_used_ff <= nodes_used_in;
         cur_ff        <= cur_in;
         halted_ff     <= halted_in;
         ovf_ff        <= ovf_in;
         cnt_ff        <= cnt_in;
         idx_ff        <= idx_in;
         rem_ff        <= rem_in;
         bits_left_ff  <= bits_left_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      sym_ff     <= sym_in;
      len_ff     <= len_in;
      bits_ff    <= bits_in;
      byte_ff    <= byte_in;
      pos_ff     <= pos_in;
      node_ff    <= node_in;
      par_ff     <= par_in;
      sym_buf_ff <= sym_buf_in;
   end

endmodule

// ===== hw/rtl/htd_rsp_stage.sv =====
// ============================================================================
// htd_rsp_stage
// Output register of the result stream; it registers the sequencer items, whose
// ready still follows the downstream ready.
// ============================================================================
module htd_rsp_stage
   import htd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   output logic                   item_ready,
   input  rsp_item_type           item,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tuser,
   output logic                   rsp_tlast
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff, item_in;

   assign item_ready = !valid_ff || rsp_tready;

   // Load a new item when the register is empty or being drained
   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (item_ready) begin
         valid_in = item_valid;
         if (item_valid) begin
            item_in = item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'd0, item_ff.overflow, item_ff.halted, item_ff.symbol};
   assign rsp_tuser  = item_ff.valid;
   assign rsp_tlast  = item_ff.last;

endmodule

// ===== hw/rtl/htd_checker.sv =====
// ============================================================================
// htd_checker
// Port-level checks of the Huffman tree decoder core, bound to the top level.
// ============================================================================
module htd_checker
   import htd_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tuser,
   input logic                   rsp_tlast
);

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // No new item while a request still has results to deliver
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("item accepted mid request");

   // A result without a symbol is the only result of its request
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && (rsp_tdata[7:0] == 8'd0))
      else $error("empty result not last");

   // Overflow only on an empty result
   a_ovf_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9] |-> !rsp_tuser)
      else $error("overflow on a symbol result");

endmodule

bind huffman_tree_decoder_core htd_checker u_htd_checker (.*);
